### rtl/core/gitdm_pkg.sv
// ----------------------------------------------------------------------------
// gitdm_pkg
// Types, constants and the segment wiring function shared by the interval
// timer and its display multiplexer.
// ----------------------------------------------------------------------------
package gitdm_pkg;

    localparam int unsigned CountW   = 10;
    localparam int unsigned PreW     = 8;
    localparam int unsigned SegW     = 8;
    localparam int unsigned EnW      = 3;
    localparam int unsigned IdxW     = 2;
    localparam int unsigned InDataW  = 8;
    localparam int unsigned OutDataW = 24;

    localparam logic [CountW-1:0] MaxTenths     = 10'd999;
    localparam logic [PreW-1:0]   TicksPerTenth = 8'd20;

    // Digit positions in multiplex order.
    localparam logic [IdxW-1:0] IdxTens   = 2'd0;
    localparam logic [IdxW-1:0] IdxUnits  = 2'd1;
    localparam logic [IdxW-1:0] IdxTenths = 2'd2;

    localparam logic [EnW-1:0] EnTens   = 3'b100;
    localparam logic [EnW-1:0] EnUnits  = 3'b010;
    localparam logic [EnW-1:0] EnTenths = 3'b001;

    // Logical segment patterns, bit 0 is a up to bit 6 is g.
    localparam logic [6:0] SegLogical [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    typedef struct packed {
        logic [CountW-1:0] value;
        logic [IdxW-1:0]   index;
    } t_disp_req;

    typedef struct packed {
        logic [SegW-1:0] segment;
        logic [EnW-1:0]  enable;
    } t_disp;

    typedef struct packed {
        logic              running;
        logic [CountW-1:0] tenths;
        logic [EnW-1:0]    enable;
        logic [SegW-1:0]   segment;
    } t_result;

    // Maps a decimal digit onto the board segment wiring. Bit 6 stays low.
    function automatic logic [SegW-1:0] wire_segments(input logic [3:0] digit);
        logic [6:0] s;
        logic [3:0] d;
        d = (digit > 4'd9) ? 4'd9 : digit;
        s = SegLogical[d];
        wire_segments = {s[4], 1'b0, s[2], s[3], s[6], s[1], s[0], s[5]};
    endfunction

endpackage

### rtl/core/gitdm_seg.sv
// ----------------------------------------------------------------------------
// gitdm_seg
// Splits the tenths count into decimal digits and encodes the selected one.
// ----------------------------------------------------------------------------
module gitdm_seg
    import gitdm_pkg::*;
(
    input  t_disp_req i_req,
    output t_disp     o_disp
);

    logic [15:0] w_hund_prod;
    logic [17:0] w_div10_prod;
    logic [14:0] w_tens_prod;
    logic [3:0]  w_hund;
    logic [6:0]  w_div10;
    logic [6:0]  w_div100q;
    logic [3:0]  w_tens;
    logic [3:0]  w_ones;
    logic [3:0]  w_digit;

    // Reciprocal multiplication, exact for every value below 1024.
    always_comb begin
        w_hund_prod  = 16'(i_req.value) * 16'd41;
        w_hund       = w_hund_prod[15:12];
        w_div10_prod = 18'(i_req.value) * 18'd205;
        w_div10      = w_div10_prod[17:11];
        w_ones       = 4'(i_req.value - 10'(w_div10) * 10'd10);
        w_tens_prod  = 15'(w_div10) * 15'd205;
        w_div100q    = 7'(w_tens_prod[14:11]);
        w_tens       = 4'(w_div10 - w_div100q * 7'd10);
    end

    always_comb begin
        case (i_req.index)
            IdxTens: begin
                w_digit       = w_hund;
                o_disp.enable = EnTens;
            end
            IdxUnits: begin
                w_digit       = w_tens;
                o_disp.enable = EnUnits;
            end
            default: begin
                w_digit       = w_ones;
                o_disp.enable = EnTenths;
            end
        endcase
        o_disp.segment = wire_segments(w_digit);
    end

endmodule

### rtl/core/gitdm_skid.sv
// ----------------------------------------------------------------------------
// gitdm_skid
// Two-entry result buffer so that input transactions continue while the
// receiver stalls, until both entries hold a result.
// ----------------------------------------------------------------------------
module gitdm_skid
    import gitdm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_pop_ready
);

    t_result    r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = o_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(i_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/core/gitdm_ctrl.sv
// ----------------------------------------------------------------------------
// gitdm_ctrl
// Gate edge handling, prescaler, saturating count and digit multiplex state.
// ----------------------------------------------------------------------------
module gitdm_ctrl
    import gitdm_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic            i_level,
    input  logic            i_tick,
    input  logic [PreW-1:0] i_ticks_per_tenth,
    output t_disp_req       o_req,
    input  t_disp           i_disp,
    output t_result         o_result
);

    logic              r_last_level, n_last_level;
    logic              r_counting, n_counting;
    logic [CountW-1:0] r_tenths, n_tenths;
    logic [IdxW-1:0]   r_index, n_index;
    logic [PreW-1:0]   r_pre, n_pre;
    logic [SegW-1:0]   r_segment, n_segment;
    logic [EnW-1:0]    r_enable, n_enable;

    logic              w_rise;
    logic              w_fall;
    logic [CountW-1:0] w_count;
    logic [PreW-1:0]   w_pre;
    logic [PreW:0]     w_pre_inc;

    always_comb begin
        w_rise  = i_level && !r_last_level;
        w_fall  = !i_level && r_last_level;
        w_count = w_rise ? '0 : r_tenths;
        w_pre   = w_rise ? '0 : r_pre;
        o_req   = '{value: w_count, index: r_index};
        w_pre_inc = {1'b0, w_pre} + 9'd1;
    end

    always_comb begin
        n_last_level = r_last_level;
        n_counting   = r_counting;
        n_tenths     = r_tenths;
        n_index      = r_index;
        n_pre        = r_pre;
        n_segment    = r_segment;
        n_enable     = r_enable;
        if (i_fire) begin
            n_last_level = i_level;
            n_counting   = w_rise ? 1'b1 : (w_fall ? 1'b0 : r_counting);
            n_tenths     = w_count;
            n_pre        = w_pre;
            if (i_tick) begin
                n_segment = i_disp.segment;
                n_enable  = i_disp.enable;
                n_index   = (r_index >= IdxTenths) ? IdxTens : r_index + 2'd1;
                if (w_pre_inc >= {1'b0, i_ticks_per_tenth}) begin
                    n_pre = '0;
                    if (n_counting && (w_count < MaxTenths)) begin
                        n_tenths = w_count + 10'd1;
                    end
                end else begin
                    n_pre = w_pre_inc[PreW-1:0];
                end
            end
        end
    end

    assign o_result = '{running: n_counting, tenths: n_tenths,
                        enable: n_enable, segment: n_segment};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level <= 1'b0;
            r_counting   <= 1'b0;
            r_tenths     <= '0;
            r_index      <= IdxTens;
            r_pre        <= '0;
            r_segment    <= '0;
            r_enable     <= '0;
        end else begin
            r_last_level <= n_last_level;
            r_counting   <= n_counting;
            r_tenths     <= n_tenths;
            r_index      <= n_index;
            r_pre        <= n_pre;
            r_segment    <= n_segment;
            r_enable     <= n_enable;
        end
    end

endmodule

### rtl/core/gated_interval_timer_with_display_mux.sv
// ----------------------------------------------------------------------------
// gated_interval_timer_with_display_mux
// Measures how long a gate stays high in tenths of a second and multiplexes
// the value onto a three-digit seven-segment display.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction on the s_axis channel carries one sample of the gate
// level and a flag for a 5 ms time base tick. Every input transaction yields
// exactly one output transaction on m_axis with the segment byte, the one-hot
// digit enable, the elapsed tenths and the running flag as they stand after
// that sample. The state is updated in the cycle the input is taken and the
// result is written into a two-entry output buffer. One transaction is
// accepted every cycle while the buffer has room; the rate is set by the
// single update stage of the timer state. When the receiver stalls, the
// buffer absorbs up to two results and then s_axis_tready drops until a
// result has been taken; no result is dropped. The ticks_per_tenth register
// is written through i_cfg_wr_en and i_cfg_wr_data; the user must write it
// only while idle, which the block does not enforce. A synchronous low reset
// clears the count, the prescaler, the digit index and the display outputs,
// empties the output buffer and sets ticks_per_tenth back to 20.
// ----------------------------------------------------------------------------
module gated_interval_timer_with_display_mux
    import gitdm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration: ticks_per_tenth.
    input  logic                i_cfg_wr_en,
    input  logic [PreW-1:0]     i_cfg_wr_data,
    // Input stream.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // Bit 0 gate_level, bit 1 tick, bits 7:2 zero.
    input  logic [InDataW-1:0]  s_axis_tdata,
    // Output stream.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // Bits 7:0 segment_port, 10:8 digit_enable, 20:11 elapsed_tenths,
    // 21 running, 23:22 zero.
    output logic [OutDataW-1:0] m_axis_tdata
);

    logic            w_tpt_nonzero;
    logic [PreW-1:0] r_tpt;
    logic            w_fire;
    t_disp_req       w_req;
    t_disp           w_disp;
    t_result         w_result;
    t_result         w_out;

    // The prescale register; a value of zero behaves like one in the
    // compare, since the incremented prescaler is always at least one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpt <= TicksPerTenth;
        end else if (i_cfg_wr_en) begin
            r_tpt <= i_cfg_wr_data;
        end
    end

    assign w_tpt_nonzero = |r_tpt;
    assign w_fire = s_axis_tvalid && s_axis_tready;

    gitdm_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (w_fire),
        .i_level           (s_axis_tdata[0]),
        .i_tick            (s_axis_tdata[1]),
        .i_ticks_per_tenth (w_tpt_nonzero ? r_tpt : 8'd1),
        .o_req             (w_req),
        .i_disp            (w_disp),
        .o_result          (w_result)
    );

    // Digit split and segment encode for the digit being refreshed.
    gitdm_seg u_seg (
        .i_req  (w_req),
        .o_disp (w_disp)
    );

    // Results wait here so the input side keeps moving during a stall.
    gitdm_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_fire),
        .i_data      (w_result),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_data      (w_out),
        .i_pop_ready (m_axis_tready)
    );

    assign m_axis_tdata = {2'b00, w_out.running, w_out.tenths, w_out.enable, w_out.segment};

endmodule

### tb/sv/tb_gated_interval_timer_with_display_mux.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gated_interval_timer_with_display_mux
// Drives gate samples and tick strobes into the interval timer. Every output
// transaction is checked field by field against a cycle-free model of the
// count, prescaler and digit multiplex that runs alongside the stream.
// ----------------------------------------------------------------------------
module tb_gated_interval_timer_with_display_mux;
    import gitdm_pkg::*;

    // Kinds of rows in the directed stimulus table.
    typedef enum logic [0:0] {
        ROW_SAMPLE,
        ROW_SET_DIVIDER
    } t_row_kind;

    // One directed row. A sample row offers one input transaction; a divider
    // row reprograms ticks_per_tenth once the display has settled. When
    // "typed" is set the expected result is the literal in "want" instead of
    // the running model's prediction.
    typedef struct packed {
        t_row_kind       kind;
        logic            gate;
        logic            tick;
        logic [PreW-1:0] divider;
        logic            typed;
        t_result         want;
    } t_directed_row;

    localparam int NumDirected = 24;

    localparam t_directed_row DirectedRows [NumDirected] = '{
        // Straight out of reset with no tick everything reads zero.
        '{ROW_SAMPLE,      1'b0, 1'b0, 8'd0,   1'b1, '0},
        // Idle ticks walk the digit multiplex through all three positions
        // and wrap, while the prescaler runs on with nothing to count.
        '{ROW_SAMPLE,      1'b0, 1'b1, 8'd0,   1'b0, '0},
        '{ROW_SAMPLE,      1'b0, 1'b1, 8'd0,   1'b0, '0},
        '{ROW_SAMPLE,      1'b0, 1'b1, 8'd0,   1'b0, '0},
        '{ROW_SET_DIVIDER, 1'b0, 1'b0, 8'd1,   1'b0, '0},
        // Rising edge without a tick: count cleared, running set.
        '{ROW_SAMPLE,      1'b1, 1'b0, 8'd0,   1'b0, '0},
        '{ROW_SAMPLE,      1'b1, 1'b1, 8'd0,   1'b0, '0},
        '{ROW_SAMPLE,      1'b1, 1'b1, 8'd0,   1'b0, '0},
        '{ROW_SAMPLE,      1'b1, 1'b1, 8'd0,   1'b0, '0},
        // No tick: the display holds its last digit.
        '{ROW_SAMPLE,      1'b1, 1'b0, 8'd0,   1'b0, '0},
        // Falling edge together with a tick: the stop comes first, so the
        // tick must not bump the frozen value.
        '{ROW_SAMPLE,      1'b0, 1'b1, 8'd0,   1'b0, '0},
        '{ROW_SAMPLE,      1'b0, 1'b1, 8'd0,   1'b0, '0},
        // A divider of zero acts like one.
        '{ROW_SET_DIVIDER, 1'b0, 1'b0, 8'd0,   1'b0, '0},
        // Rising edge and tick in the same sample: clear, then count.
        '{ROW_SAMPLE,      1'b1, 1'b1, 8'd0,   1'b0, '0},
        '{ROW_SAMPLE,      1'b1, 1'b1, 8'd0,   1'b0, '0},
        // Largest divider: the prescaler climbs without completing a step.
        '{ROW_SET_DIVIDER, 1'b0, 1'b0, 8'd255, 1'b0, '0},
        '{ROW_SAMPLE,      1'b1, 1'b1, 8'd0,   1'b0, '0},
        '{ROW_SAMPLE,      1'b1, 1'b1, 8'd0,   1'b0, '0},
        '{ROW_SAMPLE,      1'b1, 1'b1, 8'd0,   1'b0, '0},
        // Divider lowered below the prescaler mid-count: the next tick must
        // complete the step at once.
        '{ROW_SET_DIVIDER, 1'b0, 1'b0, 8'd2,   1'b0, '0},
        '{ROW_SAMPLE,      1'b1, 1'b1, 8'd0,   1'b0, '0},
        '{ROW_SAMPLE,      1'b0, 1'b0, 8'd0,   1'b0, '0},
        '{ROW_SAMPLE,      1'b1, 1'b0, 8'd0,   1'b0, '0},
        '{ROW_SET_DIVIDER, 1'b0, 1'b0, 8'd20,  1'b0, '0}
    };

    // Logical seven-segment glyphs, bit 0 is segment a up to bit 6 is g.
    localparam logic [6:0] DigitGlyph [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [PreW-1:0]     i_cfg_wr_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata;   // Bit 0 gate_level, bit 1 tick, rest zero.
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OutDataW-1:0] m_axis_tdata;   // segment_port, digit_enable,
                                         // elapsed_tenths, running, zero fill.

    // Model of the timer state as it stands after the last accepted sample.
    logic              gate_seen;
    logic              counting_now;
    logic [CountW-1:0] tenths_now;
    logic [IdxW-1:0]   digit_now;
    logic [PreW-1:0]   prescale_now;
    logic [SegW-1:0]   seg_shown;
    logic [EnW-1:0]    enable_shown;
    logic [PreW-1:0]   ticks_per_step;

    // Display words still owed by the block, oldest first.
    t_result expected_displays [$];

    int mismatches;
    int tx_idle_pct;
    int rx_stall_pct;
    int rx_hold_left;
    logic gate_run_level;

    gated_interval_timer_with_display_mux u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the handshake hangs.
    initial begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

    // Board wiring of one decimal digit. Digits above nine show as nine, and
    // bit 6 of the drive byte is never used.
    function automatic logic [SegW-1:0] seg_for_digit(input int unsigned d);
        logic [6:0]      g;
        logic [SegW-1:0] o;
        g    = DigitGlyph[(d > 9) ? 9 : d];
        o    = '0;
        o[0] = g[5];    // f
        o[1] = g[0];    // a
        o[2] = g[1];    // b
        o[3] = g[6];    // g
        o[4] = g[3];    // d
        o[5] = g[2];    // c
        o[7] = g[4];    // e
        return o;
    endfunction

    // Advances the timer model by one sample and returns the display word
    // the block must produce for it.
    function automatic t_result predict_display(input logic gate, input logic tick);
        t_result     r;
        int unsigned v;
        int unsigned nxt;
        // Edges are handled before the tick.
        if (gate && !gate_seen) begin
            tenths_now   = '0;
            prescale_now = '0;
            counting_now = 1'b1;
        end
        if (!gate && gate_seen) begin
            counting_now = 1'b0;
        end
        gate_seen = gate;
        if (tick) begin
            // The digit is taken from the count as it stood before this tick.
            v = {22'd0, tenths_now};
            case (digit_now)
                IdxTens: begin
                    seg_shown    = seg_for_digit(v / 100);
                    enable_shown = EnTens;
                end
                IdxUnits: begin
                    seg_shown    = seg_for_digit((v / 10) % 10);
                    enable_shown = EnUnits;
                end
                default: begin
                    seg_shown    = seg_for_digit(v % 10);
                    enable_shown = EnTenths;
                end
            endcase
            digit_now = (digit_now >= IdxTenths) ? IdxTens : digit_now + 1'b1;
            // A divider of zero or one makes every tick a count step.
            nxt = prescale_now + 1;
            if (nxt >= 32'(ticks_per_step)) begin
                prescale_now = '0;
                if (counting_now && tenths_now < MaxTenths) begin
                    tenths_now = tenths_now + 1'b1;
                end
            end else begin
                prescale_now = nxt[PreW-1:0];
            end
        end
        r.segment = seg_shown;
        r.enable  = enable_shown;
        r.tenths  = tenths_now;
        r.running = counting_now;
        return r;
    endfunction

    // Offers one sample and holds it until the block takes it. The display
    // word is queued at the accepting edge. Afterwards the sender may go
    // quiet, depending on the phase.
    task automatic offer_sample(input logic gate, input logic tick,
                                input logic typed, input t_result want);
        t_result predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(InDataW-2){1'b0}}, tick, gate};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        predicted = predict_display(gate, tick);
        expected_displays.push_back(typed ? want : predicted);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // Stops offering samples and waits until every owed display word has come
    // back, then lets the output buffer go quiet.
    task automatic settle_display();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_displays.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Programs ticks_per_tenth. Only done with the block idle.
    task automatic load_divider(input logic [PreW-1:0] value);
        settle_display();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        ticks_per_step = value;
    endtask

    // Mostly clean gate pulses of random length with random ticks, so that
    // counts build up and the display walks through real values; now and
    // then a single noisy sample that may or may not toggle the gate.
    task automatic sample_burst(input int n_samples);
        int sent;
        int run_len;
        logic lvl;
        sent = 0;
        while (sent < n_samples) begin
            if ($urandom_range(0, 9) < 8) begin
                lvl     = ~gate_run_level;
                run_len = lvl ? $urandom_range(4, 40) : $urandom_range(1, 8);
            end else begin
                lvl     = 1'($urandom_range(0, 1));
                run_len = 1;
            end
            gate_run_level = lvl;
            repeat (run_len) begin
                offer_sample(lvl, $urandom_range(0, 3) != 0, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Receiver side. A long hold-off requested by the stimulus takes
    // priority; otherwise tready follows the stall rate of the phase.
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // Checks each output transaction against the oldest owed display word.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_displays.size() == 0) begin
                $error("display word 0x%06h arrived with nothing expected", m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_displays.pop_front();
                if (m_axis_tdata[7:0] !== want.segment) begin
                    $error("segment_port: expected 0x%02h, got 0x%02h",
                           want.segment, m_axis_tdata[7:0]);
                    mismatches++;
                end
                if (m_axis_tdata[10:8] !== want.enable) begin
                    $error("digit_enable: expected %03b, got %03b",
                           want.enable, m_axis_tdata[10:8]);
                    mismatches++;
                end
                if (m_axis_tdata[20:11] !== want.tenths) begin
                    $error("elapsed_tenths: expected %0d, got %0d",
                           want.tenths, m_axis_tdata[20:11]);
                    mismatches++;
                end
                if (m_axis_tdata[21] !== want.running) begin
                    $error("running: expected %0b, got %0b",
                           want.running, m_axis_tdata[21]);
                    mismatches++;
                end
            end
        end
    end

    // Main sequence.
    initial begin
        int phase;
        mismatches     = 0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        rx_hold_left   = 0;
        gate_run_level = 1'b0;

        // Model state after reset.
        gate_seen      = 1'b0;
        counting_now   = 1'b0;
        tenths_now     = '0;
        digit_now      = IdxTens;
        prescale_now   = '0;
        seg_shown      = '0;
        enable_shown   = '0;
        ticks_per_step = TicksPerTenth;

        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners.
        for (int i = 0; i < NumDirected; i++) begin
            if (DirectedRows[i].kind == ROW_SET_DIVIDER) begin
                load_divider(DirectedRows[i].divider);
            end else begin
                offer_sample(DirectedRows[i].gate, DirectedRows[i].tick,
                             DirectedRows[i].typed, DirectedRows[i].want);
            end
        end
        gate_run_level = DirectedRows[NumDirected-2].gate;

        // Long run: one steady gate pulse with every sample a tick and every
        // tick a count step, so the count climbs past the hundreds boundary.
        load_divider(8'd1);
        offer_sample(1'b0, 1'b0, 1'b0, '0);
        repeat (120) offer_sample(1'b1, 1'b1, 1'b0, '0);
        offer_sample(1'b0, 1'b1, 1'b0, '0);
        gate_run_level = 1'b0;

        // Back-pressure: the receiver holds off for a long stretch while
        // samples keep coming, so the output buffer fills and s_axis_tready
        // drops. Then the sender waits for every owed word to drain.
        load_divider(8'd3);
        rx_hold_left = 60;
        sample_burst(30);
        settle_display();

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 46; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 46; end
                default: begin tx_idle_pct = 23; rx_stall_pct = 23; end
            endcase
            // Mostly short dividers so counts move; sometimes the extremes.
            case ($urandom_range(0, 5))
                0: load_divider(8'd0);
                1: load_divider(8'd255);
                default: load_divider(8'($urandom_range(1, 6)));
            endcase
            sample_burst(40);
            load_divider(8'($urandom_range(0, 4)));
            sample_burst(40);
        end

        // Wind down: nothing more is offered, wait for the last words.
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        settle_display();
        if (expected_displays.size() != 0) begin
            $error("%0d display words never arrived", expected_displays.size());
            mismatches++;
        end

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
